// File: rtl/core/sem_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the sobel edge magnitude block
// no dependencies

package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int PIXEL_W    = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  typedef logic [PIXEL_W-1:0] pixel_t;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 12'd3;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 13'd3;

  localparam pixel_t EDGE_MAX = 8'd255;

endpackage

// File: rtl/core/sem_pix_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying input pixel items
// depends on sem_pkg

interface sem_pix_if;
  logic            valid;
  logic            ready;
  logic            command;
  sem_pkg::pixel_t pixel;

  modport source (output valid, output command, output pixel, input ready);
  modport sink   (input valid, input command, input pixel, output ready);
endinterface

// File: rtl/core/sem_res_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying edge magnitude results
// depends on sem_pkg

interface sem_res_if;
  logic            valid;
  logic            ready;
  sem_pkg::pixel_t edge_res;
  logic            frame_end;

  modport source (output valid, output edge_res, output frame_end, input ready);
  modport sink   (input valid, input edge_res, input frame_end, output ready);
endinterface

// File: rtl/core/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// streaming 3x3 sobel gradient magnitude over 8-bit grayscale frames
// depends on sem_pkg, sem_pix_if, sem_res_if

// Pixels enter in raster order, one item at a time; each result is the
// saturated integer magnitude of the sobel gradient for the position
// width+1 places behind the input, 0 on the frame border, and drain items
// after a frame push out the trailing border results. The two rows above
// the input row live in one line memory with a registered read; the square
// root is an iterative unit that retires one result bit per cycle.
// A pixel item reads the line memory, then goes back to idle with no result,
// to emit with a border result, or through square and sum to saturation or
// the root steps and emit; a drain item with a result goes to emit. A result
// waits in an output register, so the next item is taken while it is still
// unclaimed; the emit cycle repeats only while an earlier result is unclaimed.

module sobel_edge_magnitude (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]         cfg_data,
  sem_pix_if.sink                                pixels,
  sem_res_if.source                              edges
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                      state;
  logic [sem_pkg::WIDTH_W-1:0]     frame_width;
  logic [sem_pkg::HEIGHT_W-1:0]    frame_height;
  logic [sem_pkg::WIDTH_W-1:0]     w_eff;
  logic [sem_pkg::HEIGHT_W-1:0]    h_eff;

  logic [sem_pkg::COL_W-1:0]       in_column;
  logic [sem_pkg::ROW_W-1:0]       in_row;
  logic [sem_pkg::COL_W-1:0]       out_column;
  logic [sem_pkg::ROW_W-1:0]       out_row;
  logic [sem_pkg::WIDTH_W-1:0]     owed;
  logic [sem_pkg::WIDTH_W-1:0]     owed_inc;

  logic [2*sem_pkg::PIXEL_W-1:0]   line_mem [sem_pkg::MAX_WIDTH];
  logic [2*sem_pkg::PIXEL_W-1:0]   rd_data;
  sem_pkg::pixel_t                 win [6];
  sem_pkg::pixel_t                 bot;
  sem_pkg::pixel_t                 top;
  sem_pkg::pixel_t                 mid;

  logic signed [11:0]              gx;
  logic signed [11:0]              gy;
  logic [9:0]                      ax;
  logic [9:0]                      ay;
  logic [19:0]                     sq_x;
  logic [19:0]                     sq_y;
  logic [20:0]                     sum;
  logic [15:0]                     rem;
  logic [15:0]                     root;
  logic [15:0]                     root_next;
  logic [15:0]                     rem_next;
  logic [15:0]                     root_bit;
  logic [16:0]                     trial;
  logic [2:0]                      step;
  sem_pkg::pixel_t                 mag;

  logic                            pix_accept;
  logic                            emit_due;
  logic                            interior;
  logic                            in_last_col;
  logic                            in_last_row;
  logic                            out_last_col;
  logic                            out_last_row;
  logic                            drain_ok;
  logic                            res_load;

  logic                            res_valid;
  sem_pkg::pixel_t                 res_edge;
  logic                            res_end;

  // effective frame size
  always_comb begin
    if (frame_width < sem_pkg::MIN_WIDTH) begin
      w_eff = sem_pkg::MIN_WIDTH;
    end else if (frame_width > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH)) begin
      w_eff = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < sem_pkg::MIN_HEIGHT) begin
      h_eff = sem_pkg::MIN_HEIGHT;
    end else if (frame_height > sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT)) begin
      h_eff = sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign pixels.ready = (state == S_IDLE);
  assign pix_accept   = pixels.valid && pixels.ready;

  assign top = rd_data[2*sem_pkg::PIXEL_W-1:sem_pkg::PIXEL_W];
  assign mid = rd_data[sem_pkg::PIXEL_W-1:0];

  assign owed_inc = owed + 12'd1;
  assign emit_due = 13'(owed_inc) > (13'(w_eff) + 13'd1);
  assign drain_ok = (in_column == '0) && (in_row == '0) && (owed != '0);

  assign in_last_col  = (12'(in_column) + 12'd1) >= w_eff;
  assign in_last_row  = (13'(in_row) + 13'd1) >= h_eff;
  assign out_last_col = (12'(out_column) + 12'd1) >= w_eff;
  assign out_last_row = (13'(out_row) + 13'd1) >= h_eff;
  assign interior = (out_row != '0) && ((13'(out_row) + 13'd2) <= h_eff) &&
                    (out_column != '0) && ((12'(out_column) + 12'd2) <= w_eff);

  // gradient of the window: left = win[0..2], center = win[3..5], right = memory + input
  always_comb begin
    gx = -$signed({4'b0, win[0]}) + $signed({4'b0, top})
         - ($signed({4'b0, win[1]}) <<< 1) + ($signed({4'b0, mid}) <<< 1)
         - $signed({4'b0, win[2]}) + $signed({4'b0, bot});
    gy = $signed({4'b0, win[0]}) + ($signed({4'b0, win[3]}) <<< 1)
         + $signed({4'b0, top}) - $signed({4'b0, win[2]})
         - ($signed({4'b0, win[5]}) <<< 1) - $signed({4'b0, bot});
  end

  // one step of the digit-by-digit square root
  always_comb begin
    root_bit = 16'h4000 >> {step, 1'b0};
    trial    = {1'b0, root} + {1'b0, root_bit};
    if ({1'b0, rem} >= trial) begin
      rem_next  = rem - trial[15:0];
      root_next = (root >> 1) + root_bit;
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

  assign res_load = (state == S_EMIT) && (!res_valid || edges.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::RESET_WIDTH;
      frame_height <= sem_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        sem_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sem_pkg::WIDTH_W-1:0];
        sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // line memory: read at transfer, write back in the following cycle
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      line_mem[in_column] <= {mid, bot};
    end
    if (pix_accept) begin
      rd_data <= line_mem[in_column];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      bot <= pixels.pixel;
    end
    if (state == S_READ) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
      ax     <= gx[11] ? 10'(-gx) : 10'(gx);
      ay     <= gy[11] ? 10'(-gy) : 10'(gy);
    end
    if (state == S_SQR) begin
      sq_x <= ax * ax;
      sq_y <= ay * ay;
    end
    if (state == S_SUM) begin
      rem  <= sum[15:0];
      root <= '0;
    end
    if (state == S_ROOT) begin
      rem  <= rem_next;
      root <= root_next;
    end
  end

  assign sum = 21'(sq_x) + 21'(sq_y);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      owed       <= '0;
      step       <= '0;
      mag        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pix_accept) begin
            if (pixels.command == sem_pkg::CMD_PIXEL) begin
              state <= S_READ;
            end else if (drain_ok) begin
              mag   <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_READ: begin
          owed <= owed_inc;
          if (in_last_col) begin
            in_column <= '0;
            in_row    <= in_last_row ? '0 : in_row + 1'b1;
          end else begin
            in_column <= in_column + 1'b1;
          end
          if (!emit_due) begin
            state <= S_IDLE;
          end else if (interior) begin
            state <= S_SQR;
          end else begin
            mag   <= '0;
            state <= S_EMIT;
          end
        end
        S_SQR: begin
          state <= S_SUM;
        end
        S_SUM: begin
          step <= '0;
          if (sum[20:16] != '0) begin
            mag   <= sem_pkg::EDGE_MAX;
            state <= S_EMIT;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          step <= step + 1'b1;
          if (step == 3'd7) begin
            mag   <= root_next[7:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_load) begin
            if (out_last_col) begin
              out_column <= '0;
              out_row    <= out_last_row ? '0 : out_row + 1'b1;
            end else begin
              out_column <= out_column + 1'b1;
            end
            if (owed != '0) begin
              owed <= owed - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (edges.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_edge <= mag;
      res_end  <= out_last_row && out_last_col;
    end
  end

  assign edges.valid     = res_valid;
  assign edges.edge_res  = res_edge;
  assign edges.frame_end = res_end;

  a_pixel_reads: assert property (@(posedge clk) disable iff (rst)
    pix_accept && (pixels.command == sem_pkg::CMD_PIXEL) |=> state == S_READ)
    else $error("pixel transfer did not start a memory read");

  a_end_on_border: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.frame_end |-> edges.edge_res == '0)
    else $error("last position of a frame carries a nonzero magnitude");

  a_owed_bound: assert property (@(posedge clk) disable iff (rst)
    owed <= sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH + 2))
    else $error("pending output count out of range");

  a_root_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) && (step == 3'd7) |=> state == S_EMIT)
    else $error("square root did not finish after eight steps");

endmodule
